// File: rtl/core/assert_macros.svh
// Assertion helpers for the string scan block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ssc_pkg.sv
package ssc_pkg;

   localparam logic       ACT_START   = 1'b0;
   localparam logic       ACT_ELEMENT = 1'b1;

   localparam logic [1:0] SIZE_BYTE   = 2'd0;
   localparam logic [1:0] SIZE_WORD   = 2'd1;

   localparam logic [1:0] REP_NONE    = 2'd0;
   localparam logic [1:0] REP_E       = 2'd1;
   localparam logic [1:0] REP_NE      = 2'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] accumulator;
      logic [31:0] start_offset;
      logic [31:0] start_count;
      logic [1:0]  element_size;
      logic        short_addressing;
      logic        direction_down;
      logic [1:0]  repeat_mode;
      logic [31:0] segment_base;
      logic [31:0] element;
   } req_type;

   typedef struct packed {
      logic [31:0] fetch_address;
      logic [31:0] offset_out;
      logic [31:0] count_out;
      logic        carry_flag;
      logic        zero_flag;
      logic        sign_flag;
      logic        overflow_flag;
      logic        adjust_flag;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic [1:0] size;
      logic       shrt;
      logic       down;
      logic [1:0] rep;
   } mode_type;

   typedef struct packed {
      logic af;
      logic of;
      logic sf;
      logic zf;
      logic cf;
   } flags_type;

endpackage

// File: rtl/core/string_scan_compare.sv
// String scan compare (SCAS with optional REPE / REPNE).
// Each result is registered, in the skid entry if the output word is still held.
// One word per cycle while req_ready; subtract, flags, offset, count update together.
// A two-entry output buffer keeps req_ready high while one result waits.
// Reset (synchronous, active high) clears state and valid flags; the block starts idle.
module string_scan_compare (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssc_pkg::rsp_type rsp_data
);

   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        offset_ff, offset_in;
   logic [31:0]        count_ff, count_in;
   logic [31:0]        base_ff, base_in;
   ssc_pkg::mode_type  mode_ff, mode_in;
   ssc_pkg::flags_type flags_ff, flags_in;
   logic               busy_ff, busy_in;

   logic               out_valid_ff, out_valid_in;
   ssc_pkg::rsp_type   out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   ssc_pkg::rsp_type   skid_ff, skid_in;

   logic               req_accept;
   logic               rsp_accept;
   ssc_pkg::rsp_type   result;

   logic               prefixed;
   logic [31:0]        mask, top, step;
   logic [31:0]        op_a, op_b, diff;
   logic [32:0]        diff_wide;
   logic [31:0]        off_eff, off_step, cnt_eff, cnt_dec;
   logic [31:0]        start_cnt_eff, next_off_eff;
   logic               start_prefixed;
   logic               zf;
   logic               finish;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign rsp_accept = out_valid_ff && rsp_ready;

   always_comb begin
      case (mode_ff.size)
         ssc_pkg::SIZE_BYTE: begin
            mask = 32'h0000_00FF;
            top  = 32'h0000_0080;
            step = 32'd1;
         end
         ssc_pkg::SIZE_WORD: begin
            mask = 32'h0000_FFFF;
            top  = 32'h0000_8000;
            step = 32'd2;
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            top  = 32'h8000_0000;
            step = 32'd4;
         end
      endcase
   end

   assign prefixed = (mode_ff.rep == ssc_pkg::REP_E) || (mode_ff.rep == ssc_pkg::REP_NE);
   assign start_prefixed = (req_data.repeat_mode == ssc_pkg::REP_E) ||
                           (req_data.repeat_mode == ssc_pkg::REP_NE);
   assign start_cnt_eff = req_data.short_addressing ? {16'h0000, req_data.start_count[15:0]}
                                                    : req_data.start_count;

   assign op_a      = acc_ff & mask;
   assign op_b      = req_data.element & mask;
   assign diff_wide = {1'b0, op_a} - {1'b0, op_b};
   assign diff      = diff_wide[31:0] & mask;
   assign zf        = (diff == 32'd0);

   assign off_eff  = mode_ff.shrt ? {16'h0000, offset_ff[15:0]} : offset_ff;
   assign off_step = mode_ff.down ? (off_eff - step) : (off_eff + step);
   assign cnt_eff  = mode_ff.shrt ? {16'h0000, count_ff[15:0]} : count_ff;
   assign cnt_dec  = cnt_eff - 32'd1;

   always_comb begin
      acc_in   = acc_ff;
      offset_in = offset_ff;
      count_in = count_ff;
      base_in  = base_ff;
      mode_in  = mode_ff;
      flags_in = flags_ff;
      busy_in  = busy_ff;
      finish   = 1'b1;
      if (req_data.action == ssc_pkg::ACT_START) begin
         acc_in    = req_data.accumulator;
         offset_in = req_data.start_offset;
         count_in  = req_data.start_count;
         base_in   = req_data.segment_base;
         mode_in   = '{size: req_data.element_size, shrt: req_data.short_addressing,
                       down: req_data.direction_down, rep: req_data.repeat_mode};
         busy_in   = !(start_prefixed && (start_cnt_eff == 32'd0));
      end else if (busy_ff) begin
         flags_in.cf = diff_wide[32];
         flags_in.zf = zf;
         flags_in.sf = |(diff & top);
         flags_in.of = |((op_a ^ op_b) & (op_a ^ diff) & top);
         flags_in.af = op_a[4] ^ op_b[4] ^ diff[4];
         offset_in = mode_ff.shrt ? {offset_ff[31:16], off_step[15:0]} : off_step;
         if (prefixed) begin
            count_in = mode_ff.shrt ? {count_ff[31:16], cnt_dec[15:0]} : cnt_dec;
            if ((mode_ff.shrt ? {16'h0000, cnt_dec[15:0]} : cnt_dec) == 32'd0) begin
               finish = 1'b1;
            end else if (mode_ff.rep == ssc_pkg::REP_E) begin
               finish = !zf;
            end else begin
               finish = zf;
            end
         end
         busy_in = !finish;
      end
   end

   assign next_off_eff = mode_in.shrt ? {16'h0000, offset_in[15:0]} : offset_in;

   always_comb begin
      result.fetch_address = base_in + next_off_eff;
      result.offset_out    = offset_in;
      result.count_out     = count_in;
      result.carry_flag    = flags_in.cf;
      result.zero_flag     = flags_in.zf;
      result.sign_flag     = flags_in.sf;
      result.overflow_flag = flags_in.of;
      result.adjust_flag   = flags_in.af;
      result.done_res      = !busy_in;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_accept) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         offset_ff     <= '0;
         count_ff      <= '0;
         base_ff       <= '0;
         mode_ff       <= '0;
         flags_ff      <= '0;
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            acc_ff    <= acc_in;
            offset_ff <= offset_in;
            count_ff  <= count_in;
            base_ff   <= base_in;
            mode_ff   <= mode_in;
            flags_ff  <= flags_in;
            busy_ff   <= busy_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`include "assert_macros.svh"

   `ASSERT_CLK(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid word without output word")
   `ASSERT_NEXT(a_idle_element_holds, clock, reset, req_accept && (req_data.action == ssc_pkg::ACT_ELEMENT) && !busy_ff, $stable(offset_ff) && $stable(count_ff) && $stable(flags_ff) && !busy_ff, "idle element changed scan state")
   `ASSERT_NEXT(a_single_scan_ends, clock, reset, req_accept && (req_data.action == ssc_pkg::ACT_ELEMENT) && busy_ff && !prefixed, !busy_ff && $stable(count_ff), "unprefixed scan did not end after one element")
   `ASSERT_NEXT(a_skid_drains_first, clock, reset, skid_valid_ff && rsp_accept, out_valid_ff && !skid_valid_ff, "skid word not moved to output")

endmodule

// File: sim/string_scan_compare_tb.sv
module string_scan_compare_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_WIDE  = 2'd3;
   localparam logic [1:0] REP_ODD    = 2'd3;

   localparam int IDLE_PCT [4]  = '{0, 64, 0, 11};
   localparam int STALL_PCT [4] = '{0, 0, 64, 11};

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ssc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ssc_pkg::rsp_type rsp_data;

   ssc_pkg::req_type word_queue [$];
   ssc_pkg::rsp_type scan_results [$];
   int               idle_pct    = 0;
   int               stall_pct   = 0;
   int               error_count = 0;
   int               scan_words  = 0;

   logic [31:0]        acc_q, off_q, cnt_q, base_q;
   ssc_pkg::mode_type  mode_q;
   ssc_pkg::flags_type flags_q;
   logic               busy_q;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   string_scan_compare i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic logic [31:0] low_part(logic [31:0] v, logic shrt);
      return shrt ? {16'h0000, v[15:0]} : v;
   endfunction

   function automatic logic [31:0] keep_high(logic [31:0] old, logic [31:0] nv, logic shrt);
      return shrt ? {old[31:16], nv[15:0]} : nv;
   endfunction

   function automatic logic [31:0] size_mask(logic [1:0] size);
      case (size)
         ssc_pkg::SIZE_BYTE: return 32'h0000_00FF;
         ssc_pkg::SIZE_WORD: return 32'h0000_FFFF;
         default:            return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic is_prefixed(logic [1:0] rep);
      return (rep == ssc_pkg::REP_E) || (rep == ssc_pkg::REP_NE);
   endfunction

   function automatic ssc_pkg::rsp_type scan_step(ssc_pkg::req_type w);
      logic [31:0]      mask, top, stp, a, b, d, off, cnt;
      logic             zf, done;
      ssc_pkg::rsp_type r;
      done = 1'b1;
      if (w.action == ssc_pkg::ACT_START) begin
         acc_q  = w.accumulator;
         off_q  = w.start_offset;
         cnt_q  = w.start_count;
         base_q = w.segment_base;
         mode_q = '{size: w.element_size, shrt: w.short_addressing,
                    down: w.direction_down, rep: w.repeat_mode};
         busy_q = !(is_prefixed(w.repeat_mode) &&
                    low_part(w.start_count, w.short_addressing) == 32'd0);
         done = !busy_q;
      end else if (busy_q) begin
         mask = size_mask(mode_q.size);
         case (mode_q.size)
            ssc_pkg::SIZE_BYTE: begin
               top = 32'h0000_0080;
               stp = 32'd1;
            end
            ssc_pkg::SIZE_WORD: begin
               top = 32'h0000_8000;
               stp = 32'd2;
            end
            default: begin
               top = 32'h8000_0000;
               stp = 32'd4;
            end
         endcase
         a  = acc_q & mask;
         b  = w.element & mask;
         d  = (a - b) & mask;
         zf = (d == 32'd0);
         flags_q.cf = (a < b);
         flags_q.zf = zf;
         flags_q.sf = |(d & top);
         flags_q.of = |((a ^ b) & (a ^ d) & top);
         flags_q.af = a[4] ^ b[4] ^ d[4];
         off = low_part(off_q, mode_q.shrt);
         off = mode_q.down ? (off - stp) : (off + stp);
         off_q = keep_high(off_q, off, mode_q.shrt);
         if (is_prefixed(mode_q.rep)) begin
            cnt   = low_part(cnt_q, mode_q.shrt) - 32'd1;
            cnt_q = keep_high(cnt_q, cnt, mode_q.shrt);
            cnt   = low_part(cnt_q, mode_q.shrt);
            if (cnt == 32'd0) done = 1'b1;
            else if (mode_q.rep == ssc_pkg::REP_E) done = !zf;
            else done = zf;
         end
         busy_q = !done;
      end
      r.fetch_address = base_q + low_part(off_q, mode_q.shrt);
      r.offset_out    = off_q;
      r.count_out     = cnt_q;
      r.carry_flag    = flags_q.cf;
      r.zero_flag     = flags_q.zf;
      r.sign_flag     = flags_q.sf;
      r.overflow_flag = flags_q.of;
      r.adjust_flag   = flags_q.af;
      r.done_res      = done;
      return r;
   endfunction

   task automatic check_rsp(ssc_pkg::rsp_type exp_w, ssc_pkg::rsp_type act_w);
      if (act_w.fetch_address !== exp_w.fetch_address) begin
         $error("fetch_address expected %h got %h", exp_w.fetch_address, act_w.fetch_address);
         error_count++;
      end
      if (act_w.offset_out !== exp_w.offset_out) begin
         $error("offset_out expected %h got %h", exp_w.offset_out, act_w.offset_out);
         error_count++;
      end
      if (act_w.count_out !== exp_w.count_out) begin
         $error("count_out expected %h got %h", exp_w.count_out, act_w.count_out);
         error_count++;
      end
      if (act_w.carry_flag !== exp_w.carry_flag) begin
         $error("carry_flag expected %b got %b", exp_w.carry_flag, act_w.carry_flag);
         error_count++;
      end
      if (act_w.zero_flag !== exp_w.zero_flag) begin
         $error("zero_flag expected %b got %b", exp_w.zero_flag, act_w.zero_flag);
         error_count++;
      end
      if (act_w.sign_flag !== exp_w.sign_flag) begin
         $error("sign_flag expected %b got %b", exp_w.sign_flag, act_w.sign_flag);
         error_count++;
      end
      if (act_w.overflow_flag !== exp_w.overflow_flag) begin
         $error("overflow_flag expected %b got %b", exp_w.overflow_flag, act_w.overflow_flag);
         error_count++;
      end
      if (act_w.adjust_flag !== exp_w.adjust_flag) begin
         $error("adjust_flag expected %b got %b", exp_w.adjust_flag, act_w.adjust_flag);
         error_count++;
      end
      if (act_w.done_res !== exp_w.done_res) begin
         $error("done_res expected %b got %b", exp_w.done_res, act_w.done_res);
         error_count++;
      end
   endtask

   function automatic ssc_pkg::req_type rand_word();
      ssc_pkg::req_type w;
      w.action           = 1'($urandom_range(1));
      w.accumulator      = $urandom;
      w.start_offset     = $urandom;
      w.start_count      = $urandom;
      w.element_size     = 2'($urandom_range(3));
      w.short_addressing = 1'($urandom_range(1));
      w.direction_down   = 1'($urandom_range(1));
      w.repeat_mode      = 2'($urandom_range(3));
      w.segment_base     = $urandom;
      w.element          = $urandom;
      return w;
   endfunction

   function automatic ssc_pkg::req_type start_word(logic [31:0] acc, logic [31:0] off,
                                                   logic [31:0] cnt, logic [1:0] size,
                                                   logic shrt, logic down,
                                                   logic [1:0] rep, logic [31:0] base);
      ssc_pkg::req_type w;
      w = rand_word();
      w.action           = ssc_pkg::ACT_START;
      w.accumulator      = acc;
      w.start_offset     = off;
      w.start_count      = cnt;
      w.element_size     = size;
      w.short_addressing = shrt;
      w.direction_down   = down;
      w.repeat_mode      = rep;
      w.segment_base     = base;
      return w;
   endfunction

   function automatic ssc_pkg::req_type element_word(logic [31:0] e);
      ssc_pkg::req_type w;
      w = rand_word();
      w.action  = ssc_pkg::ACT_ELEMENT;
      w.element = e;
      return w;
   endfunction

   task automatic add_directed();
      word_queue.push_back(element_word(32'hFFFF_FFFF));
      word_queue.push_back(start_word(32'h0000_0080, 32'hFFFF_FFFF, 32'h0000_0000,
                                      ssc_pkg::SIZE_BYTE, 1'b0, 1'b0, ssc_pkg::REP_E,
                                      32'h0000_1000));
      word_queue.push_back(start_word(32'h0000_0000, 32'h0001_FFFF, 32'h0001_0000,
                                      ssc_pkg::SIZE_WORD, 1'b1, 1'b1, ssc_pkg::REP_NE,
                                      32'hFFFF_FFFF));
      word_queue.push_back(start_word(32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0000,
                                      ssc_pkg::SIZE_BYTE, 1'b0, 1'b0, ssc_pkg::REP_NONE,
                                      32'hFFFF_FFF0));
      word_queue.push_back(element_word(32'h0000_00FF));
      word_queue.push_back(start_word(32'h0000_8000, 32'h1234_0000, 32'hABCD_0003,
                                      ssc_pkg::SIZE_WORD, 1'b1, 1'b1, ssc_pkg::REP_E,
                                      32'h0002_0000));
      repeat (3) word_queue.push_back(element_word(32'hFFFF_8000));
      word_queue.push_back(start_word(32'h7FFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF,
                                      SIZE_DWORD, 1'b0, 1'b0, ssc_pkg::REP_NE,
                                      32'h0000_0000));
      word_queue.push_back(element_word(32'hFFFF_FFFF));
      word_queue.push_back(element_word(32'h7FFF_FFFF));
      word_queue.push_back(start_word(32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0007,
                                      SIZE_WIDE, 1'b0, 1'b1, REP_ODD, 32'h0000_0100));
      word_queue.push_back(element_word(32'h0000_0000));
      word_queue.push_back(start_word(32'h0000_0041, 32'h0000_0100, 32'h0000_0005,
                                      ssc_pkg::SIZE_BYTE, 1'b0, 1'b0, ssc_pkg::REP_E,
                                      32'h8000_0000));
      word_queue.push_back(element_word(32'h0000_0041));
      word_queue.push_back(start_word(32'h0000_0010, 32'hFFFF_FFFE, 32'h0000_0002,
                                      ssc_pkg::SIZE_BYTE, 1'b1, 1'b0, ssc_pkg::REP_NE,
                                      32'h0000_0010));
      word_queue.push_back(element_word(32'h0000_0020));
      word_queue.push_back(element_word(32'h0000_0000));
      word_queue.push_back(element_word(32'h0000_0010));
   endtask

   task automatic add_scan();
      ssc_pkg::req_type w;
      logic [31:0]      mask, e, eff;
      int               n, eq_pct, sel;
      if ($urandom_range(9) == 0) begin
         word_queue.push_back(rand_word());
         return;
      end
      w = rand_word();
      w.action = ssc_pkg::ACT_START;
      sel = $urandom_range(9);
      w.repeat_mode = (sel == 0) ? ssc_pkg::REP_NONE :
                      (sel == 1) ? REP_ODD :
                      (sel < 6)  ? ssc_pkg::REP_E : ssc_pkg::REP_NE;
      case ($urandom_range(7))
         0: w.start_count = $urandom;
         1: w.start_count = $urandom & 32'hFFFF_0000;
         default: begin
            w.start_count = $urandom_range(6, 1);
            if (w.short_addressing) w.start_count[31:16] = 16'($urandom);
         end
      endcase
      if ($urandom_range(3) == 0)
         w.start_offset = $urandom_range(1) ? 32'hFFFF_FFFC : 32'h0000_0002;
      word_queue.push_back(w);
      eff = low_part(w.start_count, w.short_addressing);
      if (!is_prefixed(w.repeat_mode)) n = 1;
      else n = (eff > 32'd8) ? 8 : int'(eff);
      n += int'($urandom_range(1));
      if ($urandom_range(7) == 0) n = int'($urandom_range(n));
      mask = size_mask(w.element_size);
      eq_pct = (w.repeat_mode == ssc_pkg::REP_NE) ? 25 : 70;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < eq_pct) e = (w.accumulator & mask) | ($urandom & ~mask);
         else if (sel < eq_pct + 15) e = w.accumulator ^ (32'h1 << $urandom_range(31));
         else e = $urandom;
         word_queue.push_back(element_word(e));
      end
      scan_words += n + 1;
   endtask

   // driver: hold the word until accepted, predict at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) scan_results.push_back(scan_step(req_data));
         if (!req_valid || req_ready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= word_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (scan_results.size() == 0) begin
               $error("result word with no expected result, got %h", rsp_data);
               error_count++;
            end else begin
               check_rsp(scan_results.pop_front(), rsp_data);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      acc_q   = '0;
      off_q   = '0;
      cnt_q   = '0;
      base_q  = '0;
      mode_q  = '0;
      flags_q = '0;
      busy_q  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int p = 0; p < 4; p++) begin
         idle_pct  = IDLE_PCT[p];
         stall_pct = STALL_PCT[p];
         if (p == 0) add_directed();
         scan_words = 0;
         while (scan_words < 250) add_scan();
         // drain before the next phase
         do @(negedge clock);
         while (word_queue.size() != 0 || req_valid || scan_results.size() != 0);
      end
      repeat (10) @(negedge clock);
      if (error_count == 0 && scan_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: string_scan_compare.f
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/string_scan_compare.sv
sim/string_scan_compare_tb.sv
